>>> src/rtd_ratio_to_temperature_top_assert.svh
// Assertion macros for the RTD ratio to temperature block.
// Used by rtd_ratio_to_temperature_top; needs nothing else.
`ifndef RTD_RATIO_TO_TEMPERATURE_TOP_ASSERT_SVH
`define RTD_RATIO_TO_TEMPERATURE_TOP_ASSERT_SVH

// same-cycle implication
`define RTD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RTD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/rtd_pkg.sv
// Shared widths, constants and types for the RTD ratio to temperature block.
// No dependencies.
package rtd_pkg;

   localparam int OUT_FRAC_BITS = 8;
   localparam int FRAC_SH       = 16 - OUT_FRAC_BITS;

   localparam int TIME_W   = 32;
   localparam int RATIO_W  = 35;
   localparam int DEN_W    = 33;
   localparam int LIM_W    = DEN_W + 8;
   localparam int HUND_W   = DEN_W + 7;
   localparam int NUM_W    = 60;
   localparam int DIVR_W   = DEN_W + FRAC_SH;
   localparam int DIVN_W   = 61;
   localparam int QOUT_W   = OUT_FRAC_BITS + 14;
   localparam int DC_RW    = DIVR_W + 1;
   localparam int DC_QW    = RATIO_W;
   localparam int SQ_IN_W  = 64;
   localparam int SQ_ROOT_W = 32;
   localparam int SQ_RW    = 34;
   localparam int TEMP_W   = 22;
   localparam int SAT_W    = (QOUT_W > TEMP_W) ? QOUT_W : TEMP_W;
   localparam int LATENCY  = 76 + QOUT_W;

   localparam logic [27:0] CVD_4B_E14  = 28'd231000000;
   localparam logic [30:0] CVD_A2_E14  = 31'd1527480889;
   localparam logic [15:0] CVD_A_E7    = 16'd39083;
   localparam logic [10:0] CVD_2B_E9   = 11'd1155;
   localparam logic [24:0] ROOT1_SCALE = 25'd20000000;
   localparam logic [7:0]  WINDOW_HI   = 8'd200;
   localparam logic [6:0]  ROOT2_SCALE = 7'd100;

   localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(64'd1 << 32);
   localparam logic [DIVR_W-1:0] ROOT2_DIVISOR = DIVR_W'(CVD_2B_E9) << FRAC_SH;
   localparam logic [TEMP_W-2:0] TEMP_MAX = '1;
   localparam logic signed [TEMP_W-1:0] FIRST_ROOT_MAX =
      TEMP_W'(int'(WINDOW_HI) << OUT_FRAC_BITS);

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_REF_ZERO = 2'd1;
   localparam logic [1:0] ERR_NEG_DISC = 2'd2;

   typedef struct packed {
      logic [1:0]       err;
      logic             x_pos;
      logic [NUM_W-1:0] num;
   } sq_side_type;

   typedef struct packed {
      logic [1:0] err;
      logic       second;
   } out_side_type;

endpackage

>>> src/rtd_ratio_to_temperature_top.sv
// Top level: discharge-time ratio to Pt1000 temperature, fully pipelined.
// Depends on rtd_pkg, rtd_div_cell, rtd_sqrt_cell and the assertion header.
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  sense and reference times
//   rsp_      out         rsp_valid/rsp_stall  temperature, root select, error
//
// One request per cycle while no response is held.
// The pipeline is built mainly of three cell chains: 35-bit ratio divider, 32-step square
// root and the output divider of OUT_FRAC_BITS + 14 steps.
// Reset clears the valid line only; no clearing pass.
// A held response freezes the whole pipeline and raises req_stall.
`include "rtd_ratio_to_temperature_top_assert.svh"
module rtd_ratio_to_temperature_top import rtd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [15:0]              req_sense_time_int,
   input  logic [15:0]              req_sense_time_frac,
   input  logic [15:0]              req_ref_time_int,
   input  logic [15:0]              req_ref_time_frac,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [TEMP_W-1:0] rsp_temperature,
   output logic                     rsp_used_second_root,
   output logic [1:0]               rsp_error_code
);

   logic               advance;
   logic [LATENCY-1:0] vld_ff;

   assign rsp_valid = vld_ff[LATENCY-1];
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_valid};
      end
   end

   // capture, range check
   logic [TIME_W-1:0] sense_ff, refr_ff, sense2_ff, refr2_ff, sense3_ff, refr3_ff;
   logic [TIME_W-1:0] diff;
   logic [59:0]       negp_ff;
   logic [62:0]       posp_ff;
   logic              gt2_ff, rz2_ff;
   logic [1:0]        err3_ff;

   assign diff = sense_ff - refr_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sense_ff  <= {req_sense_time_int, req_sense_time_frac};
         refr_ff   <= {req_ref_time_int, req_ref_time_frac};
         negp_ff   <= 60'(CVD_4B_E14) * 60'(diff);
         posp_ff   <= 63'(CVD_A2_E14) * 63'(refr_ff);
         gt2_ff    <= sense_ff > refr_ff;
         rz2_ff    <= refr_ff == '0;
         sense2_ff <= sense_ff;
         refr2_ff  <= refr_ff;
         sense3_ff <= sense2_ff;
         refr3_ff  <= refr2_ff;
         if (rz2_ff) begin
            err3_ff <= ERR_REF_ZERO;
         end else if (gt2_ff && (63'(negp_ff) > posp_ff)) begin
            err3_ff <= ERR_NEG_DISC;
         end else begin
            err3_ff <= ERR_NONE;
         end
      end
   end

   // ratio divider chain
   logic [DC_RW-1:0] d1_rem  [RATIO_W+1];
   logic [DC_RW-1:0] d1_dvs  [RATIO_W+1];
   logic [DC_QW-1:0] d1_bits [RATIO_W+1];
   logic [DC_QW-1:0] d1_quot [RATIO_W+1];
   logic [1:0]       d1_err_ff [RATIO_W];

   assign d1_rem[0]  = DC_RW'(sense3_ff[TIME_W-1:3]);
   assign d1_dvs[0]  = DC_RW'(refr3_ff);
   assign d1_bits[0] = {sense3_ff[2:0], 32'b0};
   assign d1_quot[0] = '0;

   for (genvar g = 0; g < RATIO_W; g++) begin : g_div1
      rtd_div_cell u_cell (
         .clock   (clock),
         .advance (advance),
         .up_rem  (d1_rem[g]),
         .up_dvs  (d1_dvs[g]),
         .up_bits (d1_bits[g]),
         .up_quot (d1_quot[g]),
         .dn_rem  (d1_rem[g+1]),
         .dn_dvs  (d1_dvs[g+1]),
         .dn_bits (d1_bits[g+1]),
         .dn_quot (d1_quot[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d1_err_ff[0] <= err3_ff;
         for (int i = 1; i < RATIO_W; i++) begin
            d1_err_ff[i] <= d1_err_ff[i-1];
         end
      end
   end

   // discriminant
   logic [RATIO_W-1:0] ratio, mag;
   logic               x_pos;
   logic [45:0]        e_lo_ff;
   logic [44:0]        e_hi_ff;
   logic [42:0]        n_lo_ff;
   logic [41:0]        n_hi_ff;
   logic               xpos1_ff;
   logic [1:0]         err1_ff;
   logic [SQ_IN_W-1:0] prod, base, disc_ff;
   sq_side_type        e2_side_ff;

   assign ratio = d1_quot[RATIO_W];
   assign x_pos = ratio > RATIO_ONE;
   assign mag   = x_pos ? ratio - RATIO_ONE : RATIO_ONE - ratio;
   assign prod  = (SQ_IN_W'(e_hi_ff) << 18) + SQ_IN_W'(e_lo_ff);
   assign base  = SQ_IN_W'(CVD_A2_E14) << 32;

   always_ff @(posedge clock) begin
      if (advance) begin
         e_lo_ff  <= 46'(CVD_4B_E14) * 46'(mag[17:0]);
         e_hi_ff  <= 45'(CVD_4B_E14) * 45'(mag[34:18]);
         n_lo_ff  <= 43'(ROOT1_SCALE) * 43'(mag[17:0]);
         n_hi_ff  <= 42'(ROOT1_SCALE) * 42'(mag[34:18]);
         xpos1_ff <= x_pos;
         err1_ff  <= d1_err_ff[RATIO_W-1];
         disc_ff  <= xpos1_ff ? base - prod : base + prod;
         e2_side_ff.err   <= err1_ff;
         e2_side_ff.x_pos <= xpos1_ff;
         e2_side_ff.num   <= (NUM_W'(n_hi_ff) << 18) + NUM_W'(n_lo_ff);
      end
   end

   // square root chain
   logic [SQ_RW-1:0]     sq_rem  [SQ_ROOT_W+1];
   logic [SQ_ROOT_W-1:0] sq_root [SQ_ROOT_W+1];
   logic [SQ_IN_W-1:0]   sq_bits [SQ_ROOT_W+1];
   sq_side_type          sq_side_ff [SQ_ROOT_W];

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_bits[0] = disc_ff;

   for (genvar g = 0; g < SQ_ROOT_W; g++) begin : g_sqrt
      rtd_sqrt_cell u_cell (
         .clock   (clock),
         .advance (advance),
         .up_rem  (sq_rem[g]),
         .up_root (sq_root[g]),
         .up_bits (sq_bits[g]),
         .dn_rem  (sq_rem[g+1]),
         .dn_root (sq_root[g+1]),
         .dn_bits (sq_bits[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_side_ff[0] <= e2_side_ff;
         for (int i = 1; i < SQ_ROOT_W; i++) begin
            sq_side_ff[i] <= sq_side_ff[i-1];
         end
      end
   end

   // root selection
   logic [DEN_W-1:0]  den_ff;
   logic [LIM_W-1:0]  lim_ff;
   logic [HUND_W-1:0] hund_ff;
   logic [DIVR_W-1:0] sd1_ff, dvsr_ff;
   logic [DIVN_W-1:0] numer_ff;
   sq_side_type       f1_side_ff, f2_side_ff;
   out_side_type      f3_side_ff;
   logic              first;

   assign first = f2_side_ff.x_pos
                  && (f2_side_ff.num < (NUM_W'(lim_ff) << 16));

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff     <= DEN_W'({CVD_A_E7, 16'b0}) + DEN_W'(sq_root[SQ_ROOT_W]);
         f1_side_ff <= sq_side_ff[SQ_ROOT_W-1];
         lim_ff     <= LIM_W'(den_ff) * LIM_W'(WINDOW_HI);
         hund_ff    <= HUND_W'(den_ff) * HUND_W'(ROOT2_SCALE);
         sd1_ff     <= DIVR_W'(den_ff) << FRAC_SH;
         f2_side_ff <= f1_side_ff;
         if (first) begin
            numer_ff <= DIVN_W'(f2_side_ff.num) + DIVN_W'(sd1_ff >> 1);
            dvsr_ff  <= sd1_ff;
         end else begin
            numer_ff <= DIVN_W'(hund_ff) + DIVN_W'(ROOT2_DIVISOR >> 1);
            dvsr_ff  <= ROOT2_DIVISOR;
         end
         f3_side_ff.err    <= f2_side_ff.err;
         f3_side_ff.second <= !first;
      end
   end

   // output divider chain
   logic [DC_RW-1:0] d2_rem  [QOUT_W+1];
   logic [DC_RW-1:0] d2_dvs  [QOUT_W+1];
   logic [DC_QW-1:0] d2_bits [QOUT_W+1];
   logic [DC_QW-1:0] d2_quot [QOUT_W+1];
   out_side_type     d2_side_ff [QOUT_W];

   assign d2_rem[0]  = DC_RW'(numer_ff >> QOUT_W);
   assign d2_dvs[0]  = DC_RW'(dvsr_ff);
   assign d2_bits[0] = DC_QW'(numer_ff[QOUT_W-1:0]) << (DC_QW - QOUT_W);
   assign d2_quot[0] = '0;

   for (genvar g = 0; g < QOUT_W; g++) begin : g_div2
      rtd_div_cell u_cell (
         .clock   (clock),
         .advance (advance),
         .up_rem  (d2_rem[g]),
         .up_dvs  (d2_dvs[g]),
         .up_bits (d2_bits[g]),
         .up_quot (d2_quot[g]),
         .dn_rem  (d2_rem[g+1]),
         .dn_dvs  (d2_dvs[g+1]),
         .dn_bits (d2_bits[g+1]),
         .dn_quot (d2_quot[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d2_side_ff[0] <= f3_side_ff;
         for (int i = 1; i < QOUT_W; i++) begin
            d2_side_ff[i] <= d2_side_ff[i-1];
         end
      end
   end

   // saturate, mask errors, hold response
   logic [SAT_W-1:0]         quot_x;
   logic [TEMP_W-2:0]        temp_sat;
   out_side_type             last_side;
   logic signed [TEMP_W-1:0] temp_ff;
   logic                     second_ff;
   logic [1:0]               err_ff;

   assign last_side = d2_side_ff[QOUT_W-1];
   assign quot_x    = SAT_W'(d2_quot[QOUT_W][QOUT_W-1:0]);
   assign temp_sat  = (quot_x > SAT_W'(TEMP_MAX)) ? TEMP_MAX : quot_x[TEMP_W-2:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         err_ff <= last_side.err;
         if (last_side.err == ERR_NONE) begin
            temp_ff   <= {1'b0, temp_sat};
            second_ff <= last_side.second;
         end else begin
            temp_ff   <= '0;
            second_ff <= 1'b0;
         end
      end
   end

   assign rsp_temperature      = temp_ff;
   assign rsp_used_second_root = second_ff;
   assign rsp_error_code       = err_ff;

   `RTD_ASSERT_NOW(a_err_clears_data, clock, reset, rsp_valid && rsp_error_code != ERR_NONE, rsp_temperature == '0 && !rsp_used_second_root, "error response carries data")
   `RTD_ASSERT_NOW(a_first_in_window, clock, reset, rsp_valid && rsp_error_code == ERR_NONE && !rsp_used_second_root, !rsp_temperature[TEMP_W-1] && rsp_temperature <= FIRST_ROOT_MAX, "first root outside window")
   `RTD_ASSERT_NEXT(a_hold_freezes, clock, reset, rsp_valid && rsp_stall, $stable(vld_ff) && $stable(rsp_temperature), "pipeline moved while response held")

endmodule

>>> src/rtd_div_cell.sv
// One restoring division step: one quotient bit per cell, registered.
// Depends on rtd_pkg.
module rtd_div_cell import rtd_pkg::*; (
   input  logic             clock,
   input  logic             advance,
   input  logic [DC_RW-1:0] up_rem,
   input  logic [DC_RW-1:0] up_dvs,
   input  logic [DC_QW-1:0] up_bits,
   input  logic [DC_QW-1:0] up_quot,
   output logic [DC_RW-1:0] dn_rem,
   output logic [DC_RW-1:0] dn_dvs,
   output logic [DC_QW-1:0] dn_bits,
   output logic [DC_QW-1:0] dn_quot
);

   logic [DC_RW:0]   trial;
   logic             fits;
   logic [DC_RW-1:0] rem_in, rem_ff, dvs_ff;
   logic [DC_QW-1:0] bits_in, bits_ff, quot_in, quot_ff;

   always_comb begin
      trial   = {up_rem, up_bits[DC_QW-1]};
      fits    = trial >= {1'b0, up_dvs};
      rem_in  = fits ? DC_RW'(trial - {1'b0, up_dvs}) : DC_RW'(trial);
      quot_in = {up_quot[DC_QW-2:0], fits};
      bits_in = {up_bits[DC_QW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         dvs_ff  <= up_dvs;
         bits_ff <= bits_in;
         quot_ff <= quot_in;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_dvs  = dvs_ff;
   assign dn_bits = bits_ff;
   assign dn_quot = quot_ff;

endmodule

>>> src/rtd_sqrt_cell.sv
// One digit-by-digit square root step: one root bit per cell, registered.
// Depends on rtd_pkg.
module rtd_sqrt_cell import rtd_pkg::*; (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [SQ_RW-1:0]     up_rem,
   input  logic [SQ_ROOT_W-1:0] up_root,
   input  logic [SQ_IN_W-1:0]   up_bits,
   output logic [SQ_RW-1:0]     dn_rem,
   output logic [SQ_ROOT_W-1:0] dn_root,
   output logic [SQ_IN_W-1:0]   dn_bits
);

   logic [SQ_RW+1:0]     trial;
   logic [SQ_RW+1:0]     test;
   logic                 fits;
   logic [SQ_RW-1:0]     rem_in, rem_ff;
   logic [SQ_ROOT_W-1:0] root_in, root_ff;
   logic [SQ_IN_W-1:0]   bits_in, bits_ff;

   always_comb begin
      trial   = {up_rem, up_bits[SQ_IN_W-1 -: 2]};
      test    = (SQ_RW+2)'({up_root, 2'b01});
      fits    = trial >= test;
      rem_in  = fits ? SQ_RW'(trial - test) : SQ_RW'(trial);
      root_in = {up_root[SQ_ROOT_W-2:0], fits};
      bits_in = {up_bits[SQ_IN_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         bits_ff <= bits_in;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
   assign dn_bits = bits_ff;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for rtd_ratio_to_temperature_top: directed table, then random requests.
// Expected readings are predicted in exact integer math. Random idling on both sides.
// Depends on rtd_pkg and the RTL under src.
module tb_top import rtd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam bit [63:0] A_E7     = 64'd39083;
   localparam bit [63:0] A_SQ_E14 = 64'd1527480889;
   localparam bit [63:0] B4_E14   = 64'd231000000;
   localparam bit [63:0] B2_E9    = 64'd1155;
   localparam bit [63:0] ONE_Q32  = 64'h1_0000_0000;
   localparam bit [63:0] T_LIMIT  = 64'd2097151;
   localparam int        N_RANDOM = 600;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic                     second;
      logic [1:0]               err;
   } reading_type;

   typedef struct {
      bit [31:0]   sense;
      bit [31:0]   refr;
      bit          known;
      reading_type want;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [15:0] req_sense_time_int = 0, req_sense_time_frac = 0;
   logic [15:0] req_ref_time_int = 0, req_ref_time_frac = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [TEMP_W-1:0] rsp_temperature;
   logic rsp_used_second_root;
   logic [1:0] rsp_error_code;

   reading_type pending_readings[$];
   int  mismatches = 0;
   int  n_checked = 0, n_first = 0, n_second = 0, n_refzero = 0, n_negdisc = 0;
   int  stall_left = 0;
   bit  long_hold = 0;
   bit  rsp_burst = 1;
   int  n_sent = 0;

   rtd_ratio_to_temperature_top u_dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   function automatic bit [63:0] int_root(input bit [63:0] v);
      bit [63:0] acc, b;
      acc = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= acc + b) begin
            v -= acc + b;
            acc = (acc >> 1) + b;
         end else begin
            acc >>= 1;
         end
         b >>= 2;
      end
      return acc;
   endfunction

   function automatic reading_type predict_reading(input bit [31:0] sense, input bit [31:0] refr);
      reading_type rd;
      bit [63:0]   s, r, ratio, disc, den, num, dv, t;
      bit          above;
      s = sense;
      r = refr;
      rd = '0;
      if (r == 0) begin
         rd.err = ERR_REF_ZERO;
         return rd;
      end
      if (s > r && B4_E14 * (s - r) > A_SQ_E14 * r) begin
         rd.err = ERR_NEG_DISC;
         return rd;
      end
      ratio = (s << 32) / r;
      above = ratio > ONE_Q32;
      if (above) disc = (A_SQ_E14 << 32) - B4_E14 * (ratio - ONE_Q32);
      else disc = (A_SQ_E14 << 32) + B4_E14 * (ONE_Q32 - ratio);
      den = (A_E7 << 16) + int_root(disc);
      rd.second = 1;
      t = 0;
      if (above) begin
         num = (ratio - ONE_Q32) * 64'd20000000;
         if (num < den * 64'd200 * 64'd65536) begin
            rd.second = 0;
            dv = den << FRAC_SH;
            t = (num + (dv >> 1)) / dv;
         end
      end
      if (rd.second) begin
         num = den * 64'd100;
         dv = B2_E9 << FRAC_SH;
         t = (num + (dv >> 1)) / dv;
      end
      if (t > T_LIMIT) t = T_LIMIT;
      rd.temp = t[TEMP_W-1:0];
      return rd;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch in %s at %0t: got %0d, expected %0d", field, $time, got, want);
      mismatches++;
   endtask

   // request driver; call at a falling edge
   task automatic send_request(input bit [31:0] sense, input bit [31:0] refr, input int gap);
      req_sense_time_int  <= sense[31:16];
      req_sense_time_frac <= sense[15:0];
      req_ref_time_int    <= refr[31:16];
      req_ref_time_frac   <= refr[15:0];
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      pending_readings.push_back(predict_reading(sense, refr));
      n_sent++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         reading_type want;
         if (pending_readings.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = pending_readings.pop_front();
            n_checked++;
            if (rsp_error_code !== want.err)
               report_mismatch("error_code", rsp_error_code, want.err);
            if (rsp_used_second_root !== want.second)
               report_mismatch("used_second_root", rsp_used_second_root, want.second);
            if (rsp_temperature !== want.temp)
               report_mismatch("temperature", rsp_temperature, want.temp);
            case (want.err)
               ERR_REF_ZERO: n_refzero++;
               ERR_NEG_DISC: n_negdisc++;
               default: if (want.second) n_second++; else n_first++;
            endcase
         end
         stall_left = rsp_burst ? $urandom_range(0, 16) : 0;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1;
            stall_left--;
         end else begin
            rsp_stall <= long_hold;
         end
      end
   end

   // hold off the response side long enough to back up the pipeline
   initial begin
      wait (n_sent >= 200);
      @(negedge clock);
      long_hold = 1;
      repeat (400) @(negedge clock);
      long_hold = 0;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      bit [63:0] prod;
      bit [31:0] s, r;
      int gap_max, mode;

      rows.push_back('{32'd0, 32'd0, 1, '{0, 0, ERR_REF_ZERO}});
      rows.push_back('{32'hFFFF_FFFF, 32'd0, 1, '{0, 0, ERR_REF_ZERO}});
      rows.push_back('{32'hFFFF_FFFF, 32'd1, 1, '{0, 0, ERR_NEG_DISC}});
      rows.push_back('{32'd8, 32'd1, 1, '{0, 0, ERR_NEG_DISC}});
      rows.push_back('{32'd1, 32'd1, 0, '0});
      rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0});
      rows.push_back('{32'd0, 32'hFFFF_FFFF, 0, '0});
      rows.push_back('{32'h0000_FFFF, 32'h0001_0000, 0, '0});
      rows.push_back('{32'h0001_0001, 32'h0001_0000, 0, '0});
      rows.push_back('{32'd90768, 32'h0001_0000, 0, '0});
      rows.push_back('{32'd115237, 32'h0001_0000, 0, '0});
      rows.push_back('{32'd115240, 32'h0001_0000, 0, '0});
      rows.push_back('{32'd498892, 32'h0001_0000, 0, '0});
      rows.push_back('{32'd498893, 32'h0001_0000, 0, '0});
      rows.push_back('{32'hFFFF_0000, 32'h2222_0000, 0, '0});
      rows.push_back('{32'h5555_AAAA, 32'hAAAA_5555, 0, '0});

      repeat (5) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      foreach (rows[i]) begin
         row = rows[i];
         if (row.known && predict_reading(row.sense, row.refr) != row.want)
            report_mismatch("table row", i, row.want.err);
         send_request(row.sense, row.refr, $urandom_range(0, 3));
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 60 == 0) begin
            mode = $urandom_range(0, 2);
            gap_max = (mode == 0) ? 0 : 16;
            rsp_burst = (mode != 1);
         end
         r = $urandom() >> $urandom_range(0, 24);
         if (r == 0) r = 1;
         case ($urandom_range(0, 9))
            0: begin s = $urandom(); r = $urandom(); end
            1: begin s = $urandom(); r = 0; end
            2: begin s = $urandom(); r = $urandom_range(1, 255); end
            default: begin
               prod = (64'(r) * $urandom_range(600, 2100)) >> 10;
               s = prod[63:32] ? 32'hFFFF_FFFF : prod[31:0];
               s ^= $urandom_range(0, 3);
            end
         endcase
         send_request(s, r, $urandom_range(0, gap_max));
      end
      req_valid <= 0;
      rsp_burst = 1;

      while (pending_readings.size() != 0) @(negedge clock);
      repeat (LATENCY + 20) @(negedge clock);

      $display("checked %0d readings: %0d first root, %0d second root,", n_checked,
               n_first, n_second);
      $display("%0d zero reference, %0d negative discriminant; %0d mismatches", n_refzero,
               n_negdisc, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

>>> filelist.f
+incdir+src
src/rtd_pkg.sv
src/rtd_div_cell.sv
src/rtd_sqrt_cell.sv
src/rtd_ratio_to_temperature_top.sv
verif/tb_top.sv
